// ===== sv/slpg_pkg.sv =====
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types, pattern timing constants and colours for the status LED
// pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

  typedef enum logic [2:0] {
    MODE_STARTUP = 3'd0,
    MODE_BLINK   = 3'd1,
    MODE_IDLE    = 3'd2,
    MODE_HEART   = 3'd3,
    MODE_ALARM   = 3'd4
  } mode_t;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned NUM_W   = 20;
  localparam int unsigned PROD_W  = CHAN_W + NUM_W;
  localparam int unsigned QUOT_W  = 6;

  // floor(floor(c*2n/2000000)/5) == floor(c*n/5000000)
  // c*n/5000000 == ((c*n) >> 6) / 78125, and the divide by 78125 is a
  // multiply by ceil(2^39/78125), exact for dividends below 2^22
  localparam int unsigned PRE_SHIFT   = 6;
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned RECIP_SHIFT = 39;
  localparam int unsigned SCALED_W    = RECIP_SHIFT + QUOT_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(7036875);

  localparam logic [31:0] HEART_T      = 32'd2000000;
  localparam logic [31:0] HEART_HALF   = 32'd1000000;
  localparam logic [31:0] BLINK_T      = 32'd2000000;
  localparam logic [31:0] BLINK_HALF   = 32'd1000000;
  localparam logic [31:0] ALARM_T      = 32'd500000;
  localparam logic [31:0] ALARM_HALF   = 32'd250000;
  localparam logic [31:0] STARTUP_T    = 32'd700000;
  localparam logic [31:0] STARTUP_B1   = 32'd116666;
  localparam logic [31:0] STARTUP_B2   = 32'd233333;
  localparam logic [31:0] STARTUP_B3   = 32'd350000;
  localparam logic [31:0] STARTUP_B4   = 32'd466666;
  localparam logic [31:0] STARTUP_B5   = 32'd583333;

  localparam logic [7:0] STARTUP_LEVEL = 8'd51;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  localparam colour_t COL_OFF   = '{red: 8'd0,  green: 8'd0,  blue: 8'd0};
  localparam colour_t COL_BLINK = '{red: 8'd15, green: 8'd5,  blue: 8'd1};
  localparam colour_t COL_IDLE  = '{red: 8'd25, green: 8'd12, blue: 8'd23};
  localparam colour_t COL_ALARM = '{red: 8'd51, green: 8'd0,  blue: 8'd0};

  // heart base colour, one channel at a time: 0 red, 1 green, 2 blue
  function automatic logic [CHAN_W-1:0] heart_base(input logic [1:0] ch);
    logic [CHAN_W-1:0] c;
    case (ch)
      2'd0:    c = 8'd255;
      2'd1:    c = 8'd85;
      default: c = 8'd32;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/status_led_pattern_generator_top.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_generator_top
// Colour generator for one RGB status LED: startup sequence, three blink
// patterns and a triangular heart fade, driven by timestamped requests.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives exactly one response. A mode set,
// a startup step or a blink step passes through S_DIFF, S_EVAL and S_WAIT to the
// response register; a heart step goes through S_HEART as well, where the shared
// scaler handles the three channels in turn, each with a multiply and then a
// reciprocal multiply for the divide. A new request is taken while the last
// response still waits; the following one waits until that response is free.
module status_led_pattern_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        func,
  input  logic [2:0]  anim,
  input  logic [31:0] now_us,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        led_write,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [2:0]  current_mode,
  output logic        mode_rejected
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIFF  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_HEART = 5'b01000,
    S_WAIT  = 5'b10000
  } state_t;

  state_t                          state;
  slpg_pkg::mode_t                 mode;
  logic [31:0]                     pattern_start;
  slpg_pkg::colour_t               colour;

  logic                            func_r;
  logic [2:0]                      anim_r;
  logic [31:0]                     now_r;
  logic [31:0]                     elapsed;
  logic                            res_write;
  logic                            res_rej;

  logic [1:0]                      ch;
  logic [slpg_pkg::NUM_W-1:0]      num;
  logic                            div_start;
  logic                            div_done;
  logic [slpg_pkg::QUOT_W-1:0]     div_quot;

  logic                            rsp_free;
  logic                            col_zero;
  logic [31:0]                     blink_t;
  logic [31:0]                     blink_half;
  slpg_pkg::colour_t               blink_on;
  logic                            heart_go;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign col_zero  = (colour == slpg_pkg::COL_OFF);
  assign heart_go  = (state == S_EVAL) && !func_r && (mode == slpg_pkg::MODE_HEART) &&
                     (elapsed < slpg_pkg::HEART_T);
  assign div_start = heart_go || ((state == S_HEART) && div_done && (ch != 2'd2));

  always_comb begin
    blink_t    = slpg_pkg::BLINK_T;
    blink_half = slpg_pkg::BLINK_HALF;
    blink_on   = slpg_pkg::COL_IDLE;
    case (mode)
      slpg_pkg::MODE_BLINK: begin
        blink_on = slpg_pkg::COL_BLINK;
      end
      slpg_pkg::MODE_ALARM: begin
        blink_t    = slpg_pkg::ALARM_T;
        blink_half = slpg_pkg::ALARM_HALF;
        blink_on   = slpg_pkg::COL_ALARM;
      end
      default: begin
        blink_on = slpg_pkg::COL_IDLE;
      end
    endcase
  end

  slpg_scale_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .chan  (slpg_pkg::heart_base(heart_go ? 2'd0 : ch + 2'd1)),
    .num   (heart_go ? ((elapsed <= slpg_pkg::HEART_HALF) ?
                        elapsed[slpg_pkg::NUM_W-1:0] :
                        slpg_pkg::NUM_W'(slpg_pkg::HEART_T - elapsed)) : num),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode          <= slpg_pkg::MODE_IDLE;
      pattern_start <= '0;
      colour        <= slpg_pkg::COL_OFF;
      rsp_valid     <= 1'b0;
    end else begin
      if ((state == S_WAIT) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_WAIT;
          if (func_r) begin
            if (anim_r <= slpg_pkg::MODE_ALARM) begin
              mode          <= slpg_pkg::mode_t'(anim_r);
              pattern_start <= now_r;
            end
          end else begin
            unique case (mode)
              slpg_pkg::MODE_STARTUP: begin
                if (elapsed <= slpg_pkg::STARTUP_B1) begin
                  colour <= '{red: slpg_pkg::STARTUP_LEVEL, green: 8'd0, blue: 8'd0};
                end else if (elapsed <= slpg_pkg::STARTUP_B2) begin
                  colour <= slpg_pkg::COL_OFF;
                end else if (elapsed <= slpg_pkg::STARTUP_B3) begin
                  colour <= '{red: 8'd0, green: slpg_pkg::STARTUP_LEVEL, blue: 8'd0};
                end else if (elapsed <= slpg_pkg::STARTUP_B4) begin
                  colour <= slpg_pkg::COL_OFF;
                end else if (elapsed <= slpg_pkg::STARTUP_B5) begin
                  colour <= '{red: 8'd0, green: 8'd0, blue: slpg_pkg::STARTUP_LEVEL};
                end else if (elapsed < slpg_pkg::STARTUP_T) begin
                  colour <= slpg_pkg::COL_OFF;
                end
              end
              slpg_pkg::MODE_HEART: begin
                if (elapsed >= slpg_pkg::HEART_T) begin
                  pattern_start <= now_r;
                end else begin
                  state <= S_HEART;
                end
              end
              slpg_pkg::MODE_BLINK, slpg_pkg::MODE_IDLE, slpg_pkg::MODE_ALARM: begin
                if (elapsed < blink_half) begin
                  if (col_zero) begin
                    colour <= blink_on;
                  end
                end else if (elapsed < blink_t) begin
                  colour <= slpg_pkg::COL_OFF;
                end else begin
                  pattern_start <= now_r;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_HEART: begin
          if (div_done) begin
            case (ch)
              2'd0:    colour.red   <= 8'(div_quot);
              2'd1:    colour.green <= 8'(div_quot);
              default: colour.blue  <= 8'(div_quot);
            endcase
            if (ch == 2'd2) begin
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture, elapsed time, heart channel and operand, and response payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req_valid) begin
      func_r <= func;
      anim_r <= anim;
      now_r  <= now_us;
    end
    if (state == S_DIFF) begin
      elapsed <= now_r - pattern_start;
    end
    if (heart_go) begin
      ch  <= 2'd0;
      num <= (elapsed <= slpg_pkg::HEART_HALF) ? elapsed[slpg_pkg::NUM_W-1:0] :
             slpg_pkg::NUM_W'(slpg_pkg::HEART_T - elapsed);
    end else if ((state == S_HEART) && div_done) begin
      ch <= ch + 2'd1;
    end
    if (state == S_EVAL) begin
      res_rej   <= func_r && (anim_r > slpg_pkg::MODE_ALARM);
      res_write <= 1'b0;
      if (!func_r) begin
        case (mode)
          slpg_pkg::MODE_STARTUP: res_write <= elapsed < slpg_pkg::STARTUP_T;
          slpg_pkg::MODE_HEART:   res_write <= elapsed < slpg_pkg::HEART_T;
          default: begin
            res_write <= ((elapsed < blink_half) && col_zero) ||
                         ((elapsed >= blink_half) && (elapsed < blink_t) && !col_zero);
          end
        endcase
      end
    end
    if ((state == S_WAIT) && rsp_free) begin
      led_write     <= res_write;
      red           <= colour.red;
      green         <= colour.green;
      blue          <= colour.blue;
      current_mode  <= mode;
      mode_rejected <= res_rej;
    end
  end

  // checks
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    mode <= slpg_pkg::MODE_ALARM)
    else $error("mode register outside the legal set");

  a_reject_no_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(mode_rejected && led_write))
    else $error("rejected mode set also wrote the led");

  a_div_in_heart: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_HEART)
    else $error("scaler finished outside a heart step");

  a_heart_range: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) && led_write && (current_mode == slpg_pkg::MODE_HEART) |->
      (red <= 8'd51) && (green <= 8'd17) && (blue <= 8'd6))
    else $error("heart level beyond its peak");

endmodule

// ===== sv/slpg_scale_div.sv =====
// ----------------------------------------------------------------------------
// slpg_scale_div
// Shared scaler: multiplies a channel level by the fade position, then
// divides by a constant through a reciprocal multiply; product and quotient are registered.
// ----------------------------------------------------------------------------
module slpg_scale_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [slpg_pkg::CHAN_W-1:0]       chan,
  input  logic [slpg_pkg::NUM_W-1:0]        num,
  output logic                              done,
  output logic [slpg_pkg::QUOT_W-1:0]       quot
);

  logic                             busy;
  logic [slpg_pkg::PROD_W-1:0]      prod;
  logic [slpg_pkg::SCALED_W-1:0]    scaled;

  assign scaled = slpg_pkg::SCALED_W'(prod[slpg_pkg::PROD_W-1:slpg_pkg::PRE_SHIFT]) *
                  slpg_pkg::SCALED_W'(slpg_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= slpg_pkg::PROD_W'(chan) * slpg_pkg::PROD_W'(num);
    end
    if (busy) begin
      quot <= scaled[slpg_pkg::RECIP_SHIFT +: slpg_pkg::QUOT_W];
    end
  end

endmodule

// ===== tb/tb_status_led_pattern_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_status_led_pattern_generator_top
// Self-checking bench for the status LED pattern generator. A directed set of
// requests walks through every mode, the startup and blink phase edges, the
// heart peak, rejected modes and timestamp wrap. Random sequences of mode
// sets and timed updates follow. Both handshakes idle and stall at random in
// several phases. Every response is checked field by field against a
// predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------

import slpg_pkg::*;

typedef struct packed {
  bit [7:0] red;
  bit [7:0] green;
  bit [7:0] blue;
} led_rgb_t;

typedef struct {
  bit       write;
  led_rgb_t rgb;
  mode_t    mode;
  bit       rejected;
} led_outcome_t;

localparam bit [31:0] BLINK_PERIOD_US = 32'd2000000;
localparam bit [31:0] ALARM_PERIOD_US = 32'd500000;
localparam bit [31:0] FADE_PERIOD_US  = 32'd2000000;
localparam bit [31:0] STARTUP_SPAN_US = 32'd700000;
localparam bit [7:0]  STARTUP_GLOW    = 8'd51;
// fade base colour word, green:red:blue
localparam bit [23:0] FADE_BASE       = 24'h55ff20;

localparam led_rgb_t DARK        = '{red: 8'd0,  green: 8'd0,  blue: 8'd0};
localparam led_rgb_t GLOW_BLINK  = '{red: 8'd15, green: 8'd5,  blue: 8'd1};
localparam led_rgb_t GLOW_IDLE   = '{red: 8'd25, green: 8'd12, blue: 8'd23};
localparam led_rgb_t GLOW_ALARM  = '{red: 8'd51, green: 8'd0,  blue: 8'd0};
localparam led_rgb_t GLOW_RED    = '{red: STARTUP_GLOW, green: 8'd0, blue: 8'd0};
localparam led_rgb_t GLOW_GREEN  = '{red: 8'd0, green: STARTUP_GLOW, blue: 8'd0};
localparam led_rgb_t GLOW_BLUE   = '{red: 8'd0, green: 8'd0, blue: STARTUP_GLOW};

class led_pattern_scoreboard;
  mode_t        mode;
  bit [31:0]    start;
  led_rgb_t     colour;
  led_outcome_t pending_q[$];
  int           errors;
  int           checked;

  function new();
    mode    = MODE_IDLE;
    start   = 32'd0;
    colour  = DARK;
    errors  = 0;
    checked = 0;
  endfunction

  function int pending();
    return pending_q.size();
  endfunction

  function bit [7:0] fade_level(bit [7:0] c, bit [31:0] num);
    bit [63:0] v;
    v = (64'(c) * 64'd2 * 64'(num)) / 64'(FADE_PERIOD_US);
    return 8'(v / 64'd5);
  endfunction

  function bit blink_step(bit [31:0] d, bit [31:0] period, led_rgb_t on,
                          bit [31:0] now);
    bit w = 1'b0;
    if (d < period / 2) begin
      if (colour == DARK) begin
        colour = on;
        w = 1'b1;
      end
    end else if (d < period) begin
      if (colour != DARK) begin
        colour = DARK;
        w = 1'b1;
      end
    end else begin
      start = now;
    end
    return w;
  endfunction

  function bit startup_step(bit [31:0] d);
    bit w = 1'b1;
    if (d <= STARTUP_SPAN_US / 6) colour = GLOW_RED;
    else if (d <= (2 * STARTUP_SPAN_US) / 6) colour = DARK;
    else if (d <= (3 * STARTUP_SPAN_US) / 6) colour = GLOW_GREEN;
    else if (d <= (4 * STARTUP_SPAN_US) / 6) colour = DARK;
    else if (d <= (5 * STARTUP_SPAN_US) / 6) colour = GLOW_BLUE;
    else if (d < STARTUP_SPAN_US) colour = DARK;
    else w = 1'b0;
    return w;
  endfunction

  function bit fade_step(bit [31:0] d, bit [31:0] now);
    bit [31:0] num;
    if (d >= FADE_PERIOD_US) begin
      start = now;
      return 1'b0;
    end
    num = (d <= FADE_PERIOD_US / 2) ? d : FADE_PERIOD_US - d;
    colour.red   = fade_level(FADE_BASE[15:8], num);
    colour.green = fade_level(FADE_BASE[23:16], num);
    colour.blue  = fade_level(FADE_BASE[7:0], num);
    return 1'b1;
  endfunction

  function void note_request(bit f, bit [2:0] a, bit [31:0] now);
    led_outcome_t o;
    bit [31:0]    d;
    o.write    = 1'b0;
    o.rejected = 1'b0;
    if (f) begin
      if (a <= 3'(MODE_ALARM)) begin
        mode  = mode_t'(a);
        start = now;
      end else begin
        o.rejected = 1'b1;
      end
    end else begin
      d = now - start;
      case (mode)
        MODE_STARTUP: o.write = startup_step(d);
        MODE_BLINK:   o.write = blink_step(d, BLINK_PERIOD_US, GLOW_BLINK, now);
        MODE_IDLE:    o.write = blink_step(d, BLINK_PERIOD_US, GLOW_IDLE, now);
        MODE_HEART:   o.write = fade_step(d, now);
        MODE_ALARM:   o.write = blink_step(d, ALARM_PERIOD_US, GLOW_ALARM, now);
        default:      o.write = 1'b0;
      endcase
    end
    o.rgb  = colour;
    o.mode = mode;
    pending_q.push_back(o);
  endfunction

  task report_mismatch(string msg);
    $display("%0t: response %0d: %s", $time, checked, msg);
    errors++;
  endtask

  task check_result(bit w, bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [2:0] m,
                    bit rej);
    led_outcome_t o;
    if (pending_q.size() == 0) begin
      report_mismatch("response with no request outstanding");
      return;
    end
    o = pending_q.pop_front();
    if (w !== o.write)
      report_mismatch($sformatf("led_write got %0d wanted %0d", w, o.write));
    if (r !== o.rgb.red)
      report_mismatch($sformatf("red got %0d wanted %0d", r, o.rgb.red));
    if (g !== o.rgb.green)
      report_mismatch($sformatf("green got %0d wanted %0d", g, o.rgb.green));
    if (b !== o.rgb.blue)
      report_mismatch($sformatf("blue got %0d wanted %0d", b, o.rgb.blue));
    if (m !== 3'(o.mode))
      report_mismatch($sformatf("current_mode got %0d wanted %0d", m, o.mode));
    if (rej !== o.rejected)
      report_mismatch($sformatf("mode_rejected got %0d wanted %0d", rej, o.rejected));
    checked++;
  endtask
endclass

module tb_status_led_pattern_generator_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TOTAL_REQUESTS = 1450;
  localparam int DIRECTED_COUNT = 25;
  localparam int DRAIN_CYCLES   = 64;
  localparam int MARK_COUNT     = 26;

  localparam bit [31:0] PHASE_MARKS [MARK_COUNT] = '{
    32'd0, 32'd1, 32'd116666, 32'd116667, 32'd233333, 32'd233334, 32'd350000,
    32'd350001, 32'd466666, 32'd466667, 32'd583333, 32'd583334, 32'd699999,
    32'd700000, 32'd249999, 32'd250000, 32'd499999, 32'd500000, 32'd999999,
    32'd1000000, 32'd1000001, 32'd1999999, 32'd2000000, 32'd2000001,
    32'hffffffff, 32'h80000000
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        func      = 1'b0;
  logic [2:0]  anim      = 3'd0;
  logic [31:0] now_us    = 32'd0;
  logic        rsp_stall = 1'b0;
  logic        req_stall;
  logic        rsp_valid;
  logic        led_write;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [2:0]  current_mode;
  logic        mode_rejected;

  led_pattern_scoreboard sb;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int          requests_sent      = 0;
  int          quiet_cycles       = 0;
  bit [31:0]   last_now           = 32'd0;

  status_led_pattern_generator_top dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .func          (func),
    .anim          (anim),
    .now_us        (now_us),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .led_write     (led_write),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .current_mode  (current_mode),
    .mode_rejected (mode_rejected)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall)
        sb.check_result(led_write, red, green, blue, current_mode, mode_rejected);
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** status_led_pattern_generator_top: FAILED **");
        $finish;
      end
    end
  end

  task send_request(input bit f, input bit [2:0] a, input bit [31:0] n);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    func      <= f;
    anim      <= a;
    now_us    <= n;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(f, a, n);
    last_now = n;
    requests_sent++;
  endtask

  task send_update_run();
    int        count;
    int unsigned r;
    bit [31:0] t;
    bit [31:0] n;
    count = $urandom_range(3, 16);
    t = last_now;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40) n = sb.start + PHASE_MARKS[$urandom_range(0, MARK_COUNT - 1)];
      else if (r < 92) n = t + $urandom_range(0, 150000);
      else n = $urandom;
      t = n;
      send_request(1'b0, 3'($urandom_range(0, 7)), n);
    end
  endtask

  task send_random_sequence();
    int unsigned r;
    bit [31:0]   base;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      r = $urandom_range(0, 99);
      if (r < 70) base = last_now + $urandom_range(0, 3000000);
      else if (r < 85) base = 32'hffffffff - $urandom_range(0, 800000);
      else base = $urandom;
      send_request(1'b1, 3'($urandom_range(0, 4)), base);
      send_update_run();
    end else begin
      // noise: stray updates and mode sets, any mode value, any timestamp
      repeat ($urandom_range(1, 3))
        send_request(1'(($urandom_range(0, 1))), 3'($urandom_range(0, 7)), $urandom);
    end
  endtask

  initial begin
    int phase;
    bit [31:0] wrap_base;
    sb = new();
    wrap_base = 32'hfffffff0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // idle blink from reset state
    send_request(1'b0, 3'd0, 32'd0);
    send_request(1'b0, 3'd0, 32'd999999);
    send_request(1'b0, 3'd0, 32'd1000000);
    send_request(1'b0, 3'd0, 32'd2000000);
    // rejected modes
    send_request(1'b1, 3'd5, 32'd123);
    send_request(1'b1, 3'd7, 32'd456);
    // startup across timestamp wrap
    send_request(1'b1, 3'(MODE_STARTUP), wrap_base);
    send_request(1'b0, 3'd0, wrap_base + 32'd116666);
    send_request(1'b0, 3'd0, wrap_base + 32'd116667);
    send_request(1'b0, 3'd0, wrap_base + 32'd350000);
    send_request(1'b0, 3'd0, wrap_base + 32'd583333);
    send_request(1'b0, 3'd0, wrap_base + 32'd699999);
    send_request(1'b0, 3'd0, wrap_base + 32'd700000);
    // heart peak, tail and restart
    send_request(1'b1, 3'(MODE_HEART), 32'd100);
    send_request(1'b0, 3'd0, 32'd1000100);
    send_request(1'b0, 3'd0, 32'd2000099);
    send_request(1'b0, 3'd0, 32'd2000100);
    // blink with anim ignored on update
    send_request(1'b1, 3'(MODE_BLINK), 32'd5);
    send_request(1'b0, 3'd7, 32'd5);
    // alarm keeps colour left by blink
    send_request(1'b1, 3'(MODE_ALARM), 32'd10);
    send_request(1'b0, 3'd0, 32'd249999 + 32'd10);
    send_request(1'b0, 3'd0, 32'd250000 + 32'd10);
    send_request(1'b0, 3'd0, 32'd10);
    send_request(1'b0, 3'd0, 32'hffffffff);
    send_request(1'b1, 3'(MODE_IDLE), 32'd0);

    while (requests_sent < TOTAL_REQUESTS) begin
      phase = ((requests_sent - DIRECTED_COUNT) * 4) / (TOTAL_REQUESTS - DIRECTED_COUNT);
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 76;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 76;
        end
        default: begin
          sender_idle_pct    = 16;
          receiver_stall_pct = 16;
        end
      endcase
      send_random_sequence();
    end
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** status_led_pattern_generator_top: PASSED **");
    end else begin
      $display("** status_led_pattern_generator_top: FAILED **");
    end
    $finish;
  end

endmodule
